// ----- rtl/rgbl_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbl_pkg
// Shared types, constants and the sRGB linearization table for the
// sRGB to CIELAB converter.
// ----------------------------------------------------------------------------
package rgbl_pkg;

    localparam int FRAC_BITS = 8;
    localparam int QB        = 30;
    localparam int SH        = QB - FRAC_BITS;
    localparam int DIV_LAT   = 4;
    localparam int ROOT_LAT  = 62;
    localparam int LIN_DLY   = ROOT_LAT - DIV_LAT;
    localparam int LATENCY   = 3 + DIV_LAT + ROOT_LAT + 4;

    localparam logic [16:0] X_DEN   = 17'd95047;
    localparam logic [16:0] Y_DEN   = 17'd10000;
    localparam logic [16:0] Z_DEN   = 17'd108883;
    localparam logic [16:0] LIN_DEN = 17'd1000;

    localparam logic [38:0] X_RCP   = 39'((64'd1 << 48) / 64'd95047);
    localparam logic [38:0] Y_RCP   = 39'((64'd1 << 48) / 64'd10000);
    localparam logic [38:0] Z_RCP   = 39'((64'd1 << 48) / 64'd108883);
    localparam logic [38:0] LIN_RCP = 39'((64'd1 << 48) / 64'd1000);

    localparam logic [47:0] X_HALF = 48'd47523;
    localparam logic [47:0] Y_HALF = 48'd5000;
    localparam logic [47:0] Z_HALF = 48'd54441;
    localparam logic [47:0] L_HALF = 48'd500;

    localparam logic [63:0] ONE_Q   = 64'd1 << QB;
    localparam logic [63:0] HALF_Q  = 64'd1 << (QB - 1);
    localparam logic [30:0] THRESH  = 31'((64'd8856 * ONE_Q) / 64'd1000000);
    localparam logic [30:0] LIN_C   = 31'((64'd137931 * ONE_Q + 64'd500000) / 64'd1000000);
    localparam logic [41:0] RND     = 42'd1 << (SH - 1);

    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

    typedef logic [255:0][30:0] t_lin_rom;

    function automatic logic [63:0] fifth_pow(input logic [63:0] r);
        logic [63:0] p;
        p = r;
        for (int i = 0; i < 4; i++) begin
            p = (p * r) >> QB;
        end
        return p;
    endfunction

    function automatic logic [30:0] lin_value(input int c);
        logic [63:0] s;
        logic [63:0] sq;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] cc;
        cc = 64'(c);
        if (c <= 10) begin
            return 31'((cc * ONE_Q * 64'd100 + 64'd164730) / 64'd329460);
        end
        s  = (((cc * 64'd1000 + 64'd14025) << QB) + 64'd134512) / 64'd269025;
        sq = (s * s + HALF_Q) >> QB;
        lo = 64'd0;
        hi = ONE_Q + 64'd1;
        while (hi - lo > 64'd1) begin
            mid = lo + (hi - lo) / 64'd2;
            if (fifth_pow(mid) <= sq) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return 31'((sq * lo + HALF_Q) >> QB);
    endfunction

    function automatic t_lin_rom build_lin_rom();
        t_lin_rom rom;
        for (int c = 0; c < 256; c++) begin
            rom[c] = lin_value(c);
        end
        return rom;
    endfunction

    localparam t_lin_rom LIN_ROM = build_lin_rom();

endpackage

// ----- rtl/rgbl_div.sv -----
// ----------------------------------------------------------------------------
// rgbl_div
// Four-stage divider by a constant: a split reciprocal multiplication gives
// a quotient estimate that is at most one low, and a remainder compare
// corrects it.
// ----------------------------------------------------------------------------
module rgbl_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rgbl_pkg::t_tag     i_tag,
    input  logic [47:0]        i_num,
    input  logic [16:0]        i_den,
    input  logic [38:0]        i_rcp,
    output rgbl_pkg::t_tag     o_tag,
    output logic [30:0]        o_quo
);

    rgbl_pkg::t_tag r_tag [0:rgbl_pkg::DIV_LAT-1];
    logic [47:0]    r_num [0:2];
    logic [43:0]    r_pll;
    logic [42:0]    r_plh;
    logic [43:0]    r_phl;
    logic [42:0]    r_phh;
    logic [30:0]    r_qe1;
    logic [30:0]    r_qe2;
    logic [47:0]    r_qd;
    logic [30:0]    r_quo;
    logic [86:0]    n_prod;
    logic [47:0]    n_rem;

    always_comb begin
        n_prod = 87'(r_pll) + (87'(r_plh) << 20) + (87'(r_phl) << 24)
               + (87'(r_phh) << 44);
        n_rem  = r_num[2] - r_qd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rgbl_pkg::DIV_LAT; k++) begin
                r_tag[k].valid <= 1'b0;
            end
        end else begin
            r_tag[0].valid <= i_tag.valid;
            for (int k = 1; k < rgbl_pkg::DIV_LAT; k++) begin
                r_tag[k].valid <= r_tag[k-1].valid;
            end
        end
        r_tag[0].last <= i_tag.last;
        for (int k = 1; k < rgbl_pkg::DIV_LAT; k++) begin
            r_tag[k].last <= r_tag[k-1].last;
        end
        r_pll    <= 44'(i_num[23:0]) * 44'(i_rcp[19:0]);
        r_plh    <= 43'(i_num[23:0]) * 43'(i_rcp[38:20]);
        r_phl    <= 44'(i_num[47:24]) * 44'(i_rcp[19:0]);
        r_phh    <= 43'(i_num[47:24]) * 43'(i_rcp[38:20]);
        r_num[0] <= i_num;
        r_qe1    <= n_prod[78:48];
        r_num[1] <= r_num[0];
        r_qd     <= 48'(r_qe1) * 48'(i_den);
        r_qe2    <= r_qe1;
        r_num[2] <= r_num[1];
        r_quo    <= (n_rem >= 48'(i_den)) ? r_qe2 + 31'd1 : r_qe2;
    end

    assign o_tag = r_tag[rgbl_pkg::DIV_LAT-1];
    assign o_quo = r_quo;

endmodule

// ----- rtl/rgbl_matrix.sv -----
// ----------------------------------------------------------------------------
// rgbl_matrix
// Linearizes the three channel bytes and forms the rounded dividends of
// the X, Y and Z matrix rows.
// ----------------------------------------------------------------------------
module rgbl_matrix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rgbl_pkg::t_tag     i_tag,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    output rgbl_pkg::t_tag     o_tag,
    output logic [47:0]        o_num_x,
    output logic [47:0]        o_num_y,
    output logic [47:0]        o_num_z
);

    rgbl_pkg::t_tag r_tag0;
    rgbl_pkg::t_tag r_tag1;
    rgbl_pkg::t_tag r_tag2;
    logic [30:0]    r_lr;
    logic [30:0]    r_lg;
    logic [30:0]    r_lb;
    logic [44:0]    r_p [0:8];
    logic [47:0]    r_nx;
    logic [47:0]    r_ny;
    logic [47:0]    r_nz;
    logic [47:0]    n_sx;
    logic [47:0]    n_sy;
    logic [47:0]    n_sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag0.valid <= 1'b0;
            r_tag1.valid <= 1'b0;
            r_tag2.valid <= 1'b0;
        end else begin
            r_tag0.valid <= i_tag.valid;
            r_tag1.valid <= r_tag0.valid;
            r_tag2.valid <= r_tag1.valid;
        end
        r_tag0.last <= i_tag.last;
        r_tag1.last <= r_tag0.last;
        r_tag2.last <= r_tag1.last;
        r_lr <= rgbl_pkg::LIN_ROM[i_red];
        r_lg <= rgbl_pkg::LIN_ROM[i_green];
        r_lb <= rgbl_pkg::LIN_ROM[i_blue];
        r_p[0] <= 45'(r_lr) * 45'd4124;
        r_p[1] <= 45'(r_lg) * 45'd3576;
        r_p[2] <= 45'(r_lb) * 45'd1805;
        r_p[3] <= 45'(r_lr) * 45'd2126;
        r_p[4] <= 45'(r_lg) * 45'd7152;
        r_p[5] <= 45'(r_lb) * 45'd722;
        r_p[6] <= 45'(r_lr) * 45'd193;
        r_p[7] <= 45'(r_lg) * 45'd1192;
        r_p[8] <= 45'(r_lb) * 45'd9505;
        r_nx <= (n_sx << 3) + (n_sx << 1) + rgbl_pkg::X_HALF;
        r_ny <= n_sy + rgbl_pkg::Y_HALF;
        r_nz <= (n_sz << 3) + (n_sz << 1) + rgbl_pkg::Z_HALF;
    end

    always_comb begin
        n_sx = 48'(r_p[0]) + 48'(r_p[1]) + 48'(r_p[2]);
        n_sy = 48'(r_p[3]) + 48'(r_p[4]) + 48'(r_p[5]);
        n_sz = 48'(r_p[6]) + 48'(r_p[7]) + 48'(r_p[8]);
    end

    assign o_tag   = r_tag2;
    assign o_num_x = r_nx;
    assign o_num_y = r_ny;
    assign o_num_z = r_nz;

endmodule

// ----- rtl/rgbl_labf.sv -----
// ----------------------------------------------------------------------------
// rgbl_labf
// CIELAB companding function: a bit-per-step cube root pipeline for the
// upper range and a pipelined divide for the linear segment below it.
// ----------------------------------------------------------------------------
module rgbl_labf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rgbl_pkg::t_tag     i_tag,
    input  logic [30:0]        i_t,
    output rgbl_pkg::t_tag     o_tag,
    output logic [30:0]        o_f
);

    rgbl_pkg::t_tag r_tag0;
    logic [30:0]    r_t0;
    logic           r_big0;
    logic [47:0]    r_num0;
    logic [30:0]    w_quo;
    logic [30:0]    r_dly [0:rgbl_pkg::LIN_DLY-1];

    rgbl_pkg::t_tag r_atag  [0:30];
    logic [30:0]    r_at    [0:30];
    logic           r_abig  [0:30];
    logic [30:0]    r_aroot [0:30];
    logic [30:0]    r_acand [0:30];
    logic [31:0]    r_asq   [0:30];
    rgbl_pkg::t_tag r_btag  [0:30];
    logic [30:0]    r_bt    [0:30];
    logic           r_bbig  [0:30];
    logic [30:0]    r_broot [0:30];

    rgbl_pkg::t_tag r_otag;
    logic [30:0]    r_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag0.valid <= 1'b0;
        end else begin
            r_tag0.valid <= i_tag.valid;
        end
        r_tag0.last <= i_tag.last;
        r_t0        <= i_t;
        r_big0      <= (i_t > rgbl_pkg::THRESH);
        r_num0      <= 48'(i_t) * 48'd7787 + rgbl_pkg::L_HALF;
    end

    rgbl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag0),
        .i_num   (r_num0),
        .i_den   (rgbl_pkg::LIN_DEN),
        .i_rcp   (rgbl_pkg::LIN_RCP),
        .o_tag   (),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        r_dly[0] <= w_quo;
        for (int k = 1; k < rgbl_pkg::LIN_DLY; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    for (genvar j = 0; j < 31; j++) begin : g_step
        localparam int B = 30 - j;
        rgbl_pkg::t_tag w_tag;
        logic [30:0]    w_t;
        logic           w_big;
        logic [30:0]    w_root;
        logic [30:0]    n_cand;
        logic [63:0]    n_sqf;
        logic [63:0]    n_cubef;
        logic [32:0]    n_cube;

        if (j == 0) begin : g_first
            assign w_tag  = r_tag0;
            assign w_t    = r_t0;
            assign w_big  = r_big0;
            assign w_root = 31'd0;
        end else begin : g_next
            assign w_tag  = r_btag[j-1];
            assign w_t    = r_bt[j-1];
            assign w_big  = r_bbig[j-1];
            assign w_root = r_broot[j-1];
        end

        always_comb begin
            n_cand  = w_root | (31'd1 << B);
            n_sqf   = 64'(n_cand) * 64'(n_cand);
            n_cubef = 64'(r_asq[j]) * 64'(r_acand[j]);
            n_cube  = n_cubef[62:30];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_atag[j].valid <= 1'b0;
                r_btag[j].valid <= 1'b0;
            end else begin
                r_atag[j].valid <= w_tag.valid;
                r_btag[j].valid <= r_atag[j].valid;
            end
            r_atag[j].last <= w_tag.last;
            r_at[j]        <= w_t;
            r_abig[j]      <= w_big;
            r_aroot[j]     <= w_root;
            r_acand[j]     <= n_cand;
            r_asq[j]       <= n_sqf[61:30];
            r_btag[j].last <= r_atag[j].last;
            r_bt[j]        <= r_at[j];
            r_bbig[j]      <= r_abig[j];
            r_broot[j]     <= (n_cube <= {2'b00, r_at[j]}) ? r_acand[j] : r_aroot[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_otag.valid <= 1'b0;
        end else begin
            r_otag.valid <= r_btag[30].valid;
        end
        r_otag.last <= r_btag[30].last;
        r_f <= r_bbig[30] ? r_broot[30] : r_dly[rgbl_pkg::LIN_DLY-1] + rgbl_pkg::LIN_C;
    end

    assign o_tag = r_otag;
    assign o_f   = r_f;

endmodule

// ----- rtl/rgb_to_cielab_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_cielab_converter
// Converts one 8-bit sRGB pixel per clock to CIELAB (D65, 2-degree
// observer) with FRAC_BITS fraction bits and saturating outputs.
//
// Channel   Direction  Handshake         Payload
// request   in         start / busy      i_red, i_green, i_blue, i_last_pixel
// result    out        o_valid strobe    o_lightness, o_green_red,
//                                        o_blue_yellow, o_last_out
//
// A request is taken in every cycle; busy is always low.
// Each result passes, in order, through the linearization, product and
// sum registers of the matrix, 4 stages of reciprocal division, the
// companding stage (an input register, two multiply stages per root bit
// and a select register), and 2 output stages.
// Synchronous reset clears all valid bits; payload registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module rgb_to_cielab_converter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    input  logic                i_last_pixel,
    output logic                o_valid,
    output logic [14:0]         o_lightness,
    output logic signed [15:0]  o_green_red,
    output logic signed [15:0]  o_blue_yellow,
    output logic                o_last_out
);

    function automatic logic signed [41:0] round_q(input logic signed [41:0] v);
        logic [41:0] m;
        logic [41:0] r;
        m = v[41] ? 42'(-v) : 42'(v);
        r = (m + rgbl_pkg::RND) >> rgbl_pkg::SH;
        return v[41] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [15:0] clamp16(input logic signed [41:0] v,
                                            input logic signed [41:0] lo);
        logic [15:0] res;
        if (v < lo) begin
            res = 16'(lo);
        end else if (v > 42'sd32767) begin
            res = 16'h7fff;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    rgbl_pkg::t_tag w_in_tag;
    rgbl_pkg::t_tag w_m_tag;
    rgbl_pkg::t_tag w_d_tag;
    rgbl_pkg::t_tag w_f_tag;
    logic [47:0]    w_num_x;
    logic [47:0]    w_num_y;
    logic [47:0]    w_num_z;
    logic [30:0]    w_x;
    logic [30:0]    w_y;
    logic [30:0]    w_z;
    logic [30:0]    w_fx;
    logic [30:0]    w_fy;
    logic [30:0]    w_fz;

    rgbl_pkg::t_tag     r_tag1;
    logic signed [41:0] r_lraw;
    logic signed [41:0] r_araw;
    logic signed [41:0] r_braw;
    logic               r_valid;
    logic               r_last;
    logic [14:0]        r_lightness;
    logic [15:0]        r_green_red;
    logic [15:0]        r_blue_yellow;
    logic [15:0]        n_light;

    assign busy           = 1'b0;
    assign w_in_tag.valid = start;
    assign w_in_tag.last  = i_last_pixel;

    rgbl_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_in_tag),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_tag   (w_m_tag),
        .o_num_x (w_num_x),
        .o_num_y (w_num_y),
        .o_num_z (w_num_z)
    );

    rgbl_div u_div_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_tag (w_m_tag),
        .i_num (w_num_x), .i_den (rgbl_pkg::X_DEN), .i_rcp (rgbl_pkg::X_RCP),
        .o_tag (w_d_tag), .o_quo (w_x)
    );

    rgbl_div u_div_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_tag (w_m_tag),
        .i_num (w_num_y), .i_den (rgbl_pkg::Y_DEN), .i_rcp (rgbl_pkg::Y_RCP),
        .o_tag (), .o_quo (w_y)
    );

    rgbl_div u_div_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_tag (w_m_tag),
        .i_num (w_num_z), .i_den (rgbl_pkg::Z_DEN), .i_rcp (rgbl_pkg::Z_RCP),
        .o_tag (), .o_quo (w_z)
    );

    rgbl_labf u_labf_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_tag (w_d_tag),
        .i_t (w_x), .o_tag (w_f_tag), .o_f (w_fx)
    );

    rgbl_labf u_labf_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_tag (w_d_tag),
        .i_t (w_y), .o_tag (), .o_f (w_fy)
    );

    rgbl_labf u_labf_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_tag (w_d_tag),
        .i_t (w_z), .o_tag (), .o_f (w_fz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1.valid <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_tag1.valid <= w_f_tag.valid;
            r_valid      <= r_tag1.valid;
        end
        r_tag1.last <= w_f_tag.last;
        r_last      <= r_tag1.last;
        r_lraw <= 42'sd116 * $signed({11'd0, w_fy}) - $signed(42'(rgbl_pkg::ONE_Q << 4));
        r_araw <= 42'sd500 * ($signed({11'd0, w_fx}) - $signed({11'd0, w_fy}));
        r_braw <= 42'sd200 * ($signed({11'd0, w_fy}) - $signed({11'd0, w_fz}));
        r_lightness   <= n_light[14:0];
        r_green_red   <= clamp16(round_q(r_araw), -42'sd32768);
        r_blue_yellow <= clamp16(round_q(r_braw), -42'sd32768);
    end

    always_comb begin
        n_light = clamp16(round_q(r_lraw), 42'sd0);
    end

    assign o_valid       = r_valid;
    assign o_last_out    = r_last;
    assign o_lightness   = r_lightness;
    assign o_green_red   = $signed(r_green_red);
    assign o_blue_yellow = $signed(r_blue_yellow);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##(rgbl_pkg::LATENCY) o_valid)
        else $error("request produced no result");

    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, rgbl_pkg::LATENCY))
        else $error("result without request");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_out == $past(i_last_pixel, rgbl_pkg::LATENCY)))
        else $error("last flag mismatch");

endmodule
